/* rtl/quaternion_point_transform_assert.svh */
// Assertion macros for the quaternion point transform.
// Used by quaternion_point_transform.sv; expects aclk and aresetn in scope.
`ifndef QUATERNION_POINT_TRANSFORM_ASSERT_SVH
`define QUATERNION_POINT_TRANSFORM_ASSERT_SVH

// Checked on every clock edge outside reset.
`define QPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define QPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/qpt_pkg.sv */
// Shared types and constants of the quaternion point transform.
// Has no dependencies; used by quaternion_point_transform.sv.
package qpt_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_ROT_W   = 3'd0;
    localparam logic [2:0] REG_ROT_X   = 3'd1;
    localparam logic [2:0] REG_ROT_Y   = 3'd2;
    localparam logic [2:0] REG_ROT_Z   = 3'd3;
    localparam logic [2:0] REG_SHIFT_X = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y = 3'd5;
    localparam logic [2:0] REG_SHIFT_Z = 3'd6;

    // Rotation matrix entry, Q.30 with headroom.
    typedef logic signed [32:0] coef_t;

    // Reset value of rot_w (1.0 in Q3.28) and of a diagonal entry (1.0 in Q.30).
    localparam logic signed [31:0] ROT_W_ONE = 32'sh1000_0000;
    localparam coef_t              COEF_ONE  = 33'sh0_4000_0000;

    // Rounding offset for a shift by 30 bits.
    localparam logic signed [66:0] HALF_Q30 = 67'sd536870912;

endpackage

/* rtl/quaternion_point_transform.sv */
// Quaternion point transform top level: configuration registers,
// normalization sequencer and point pipeline. Depends on qpt_pkg and the assert header.
//
// Rotates a Q15.16 point by a configured quaternion and adds a configured
// translation. The point path is a four-stage pipeline (products, row sums,
// rounding plus translation, saturation) that takes one transfer per clock
// while the output is not stalled and normalization is idle. Writing any
// rotation register starts the normalization sequencer, which derives the 3x3
// rotation matrix with one shared 32x32 multiplier, a one-bit-per-cycle square
// root and a one-bit-per-cycle divider; while it runs, s_ready is low. It takes up
// to 30 scaling steps, 4 squares, 32 root steps, 4 x 62 divide steps, 10 products
// and 9 matrix entries. After reset the matrix is the identity.
`include "quaternion_point_transform_assert.svh"

module quaternion_point_transform (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_base_x,
    output logic signed [31:0] m_base_y,
    output logic signed [31:0] m_base_z,
    output logic               m_zero_norm
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_SCALE, ST_SQSUM, ST_SQRT, ST_DIV, ST_PROD, ST_ENTRY
    } seq_state_t;

    // Configuration registers.
    logic signed [31:0] rot_reg [4];
    logic signed [31:0] shift_reg [3];
    logic [2:0]         reg_idx;
    logic               wr_en;
    logic               rot_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign rot_wr  = wr_en && (reg_idx[2] == 1'b0);

    // Register write on the access phase of a write transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0]   <= qpt_pkg::ROT_W_ONE;
            rot_reg[1]   <= '0;
            rot_reg[2]   <= '0;
            rot_reg[3]   <= '0;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                qpt_pkg::REG_ROT_W:   rot_reg[0]   <= pwdata;
                qpt_pkg::REG_ROT_X:   rot_reg[1]   <= pwdata;
                qpt_pkg::REG_ROT_Y:   rot_reg[2]   <= pwdata;
                qpt_pkg::REG_ROT_Z:   rot_reg[3]   <= pwdata;
                qpt_pkg::REG_SHIFT_X: shift_reg[0] <= pwdata;
                qpt_pkg::REG_SHIFT_Y: shift_reg[1] <= pwdata;
                qpt_pkg::REG_SHIFT_Z: shift_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (reg_idx)
            qpt_pkg::REG_ROT_W:   prdata = rot_reg[0];
            qpt_pkg::REG_ROT_X:   prdata = rot_reg[1];
            qpt_pkg::REG_ROT_Y:   prdata = rot_reg[2];
            qpt_pkg::REG_ROT_Z:   prdata = rot_reg[3];
            qpt_pkg::REG_SHIFT_X: prdata = shift_reg[0];
            qpt_pkg::REG_SHIFT_Y: prdata = shift_reg[1];
            qpt_pkg::REG_SHIFT_Z: prdata = shift_reg[2];
            default:              prdata = '0;
        endcase
    end

    // Normalization sequencer state.
    seq_state_t          state_reg;
    logic signed [32:0]  a_reg [4];
    logic [1:0]          idx_reg;
    logic [63:0]         s_reg;
    logic [63:0]         res_reg;
    logic [63:0]         bit_reg;
    logic [31:0]         root_reg;
    logic [61:0]         num_reg;
    logic [31:0]         rem_reg;
    logic [31:0]         q_reg;
    logic [5:0]          cnt_reg;
    logic [3:0]          step_reg;
    logic signed [31:0]  u_reg [4];
    logic signed [63:0]  prod_reg [10];
    qpt_pkg::coef_t      mat_reg [9];
    logic                zero_reg;
    logic                busy;

    assign busy = (state_reg != ST_IDLE);

    // Magnitudes and the largest one, for prescaling.
    logic [32:0] a_mag [4];
    logic [32:0] mag_max;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            a_mag[k] = a_reg[k][32] ? 33'(-a_reg[k]) : 33'(a_reg[k]);
        end
        mag_max = a_mag[0];
        for (int k = 1; k < 4; k++) begin
            if (a_mag[k] > mag_max) begin
                mag_max = a_mag[k];
            end
        end
    end

    // Shared multiplier operand selection.
    logic signed [31:0] mul_x;
    logic signed [31:0] mul_y;
    logic signed [63:0] mul_p;
    always_comb begin
        mul_x = a_reg[idx_reg][31:0];
        mul_y = a_reg[idx_reg][31:0];
        if (state_reg == ST_PROD) begin
            case (step_reg)
                4'd0:    begin mul_x = u_reg[0]; mul_y = u_reg[0]; end
                4'd1:    begin mul_x = u_reg[1]; mul_y = u_reg[1]; end
                4'd2:    begin mul_x = u_reg[2]; mul_y = u_reg[2]; end
                4'd3:    begin mul_x = u_reg[3]; mul_y = u_reg[3]; end
                4'd4:    begin mul_x = u_reg[1]; mul_y = u_reg[2]; end
                4'd5:    begin mul_x = u_reg[0]; mul_y = u_reg[3]; end
                4'd6:    begin mul_x = u_reg[1]; mul_y = u_reg[3]; end
                4'd7:    begin mul_x = u_reg[0]; mul_y = u_reg[2]; end
                4'd8:    begin mul_x = u_reg[2]; mul_y = u_reg[3]; end
                default: begin mul_x = u_reg[0]; mul_y = u_reg[1]; end
            endcase
        end
    end
    assign mul_p = mul_x * mul_y;

    // Square root step and divide step.
    logic [63:0] trial;
    logic [32:0] rem_sh;
    logic        q_bit;
    logic [31:0] q_next;
    logic [32:0] rem_next;
    assign trial    = res_reg + bit_reg;
    assign rem_sh   = {rem_reg, num_reg[61]};
    assign q_bit    = (rem_sh >= {1'b0, root_reg});
    assign rem_next = q_bit ? (rem_sh - {1'b0, root_reg}) : rem_sh;
    assign q_next   = {q_reg[30:0], q_bit};

    // Root after the final step, where bit is one.
    logic [31:0] root_fin;
    assign root_fin = (s_reg >= trial) ? (res_reg[32:1] + 32'd1) : res_reg[32:1];

    // Numerator of the next component: |a| * 2^30 + r / 2.
    logic [61:0] num_load;
    logic [1:0]  idx_load;
    logic [31:0] root_use;
    assign idx_load = (state_reg == ST_SQRT) ? 2'd0 : (idx_reg + 2'd1);
    assign root_use = (state_reg == ST_SQRT) ? root_fin : root_reg;
    assign num_load = {a_mag[idx_load][30:0], 31'b0} >> 1;

    // Matrix entry from the stored products.
    logic signed [65:0] entry_sum;
    qpt_pkg::coef_t     entry_val;
    logic signed [65:0] pe [10];
    always_comb begin
        for (int k = 0; k < 10; k++) begin
            pe[k] = 66'(prod_reg[k]);
        end
        case (step_reg)
            4'd0:    entry_sum = pe[0] + pe[1] - pe[2] - pe[3];
            4'd1:    entry_sum = (pe[4] - pe[5]) <<< 1;
            4'd2:    entry_sum = (pe[6] + pe[7]) <<< 1;
            4'd3:    entry_sum = (pe[4] + pe[5]) <<< 1;
            4'd4:    entry_sum = pe[0] - pe[1] + pe[2] - pe[3];
            4'd5:    entry_sum = (pe[8] - pe[9]) <<< 1;
            4'd6:    entry_sum = (pe[6] - pe[7]) <<< 1;
            4'd7:    entry_sum = (pe[8] + pe[9]) <<< 1;
            default: entry_sum = pe[0] - pe[1] - pe[2] + pe[3];
        endcase
        entry_val = qpt_pkg::coef_t'((entry_sum + 66'sd536870912) >>> 30);
    end

    // Sequencer: prescale, sum of squares, root, four divisions, matrix.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            zero_reg  <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            step_reg  <= '0;
            for (int k = 0; k < 9; k++) begin
                mat_reg[k] <= (k == 0 || k == 4 || k == 8) ? qpt_pkg::COEF_ONE : '0;
            end
        end else if (rot_wr) begin
            state_reg <= ST_LOAD;
        end else begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_LOAD: begin
                    for (int k = 0; k < 4; k++) begin
                        a_reg[k] <= 33'(rot_reg[k]);
                    end
                    if (rot_reg[0] == '0 && rot_reg[1] == '0 &&
                        rot_reg[2] == '0 && rot_reg[3] == '0) begin
                        zero_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        zero_reg  <= 1'b0;
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (mag_max > 33'h0_4000_0000) begin
                        for (int k = 0; k < 4; k++) begin
                            a_reg[k] <= a_reg[k][32] ? -33'(a_mag[k] >> 1)
                                                     : 33'(a_mag[k] >> 1);
                        end
                        idx_reg   <= '0;
                        s_reg     <= '0;
                        state_reg <= ST_SQSUM;
                    end else if (mag_max < 33'h0_2000_0000) begin
                        for (int k = 0; k < 4; k++) begin
                            a_reg[k] <= a_reg[k] <<< 1;
                        end
                    end else begin
                        idx_reg   <= '0;
                        s_reg     <= '0;
                        state_reg <= ST_SQSUM;
                    end
                end
                ST_SQSUM: begin
                    s_reg   <= s_reg + 64'(mul_p);
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        res_reg   <= '0;
                        bit_reg   <= 64'h4000_0000_0000_0000;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (s_reg >= trial) begin
                        s_reg   <= s_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == 64'd1) begin
                        // Final root step also loads the first division.
                        root_reg  <= root_use;
                        num_reg   <= num_load + 62'(root_use >> 1);
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_next[31:0];
                    q_reg   <= q_next;
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd61) begin
                        u_reg[idx_reg] <= a_reg[idx_reg][32] ? -q_next : q_next;
                        if (idx_reg == 2'd3) begin
                            step_reg  <= '0;
                            state_reg <= ST_PROD;
                        end else begin
                            idx_reg <= idx_load;
                            num_reg <= num_load + 62'(root_use >> 1);
                            rem_reg <= '0;
                            q_reg   <= '0;
                            cnt_reg <= '0;
                        end
                    end
                end
                ST_PROD: begin
                    prod_reg[step_reg] <= mul_p;
                    if (step_reg == 4'd9) begin
                        step_reg  <= '0;
                        state_reg <= ST_ENTRY;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_ENTRY: begin
                    mat_reg[step_reg] <= entry_val;
                    if (step_reg == 4'd8) begin
                        step_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
            endcase
        end
    end

    // Point pipeline: every stage moves when the output stage can take a transfer.
    logic               advance;
    logic               v1_reg, v2_reg, v3_reg, out_v_reg;
    logic               z1_reg, z2_reg, z3_reg;
    logic signed [64:0] p1_reg [9];
    logic signed [66:0] acc2_reg [3];
    logic signed [37:0] sum3_reg [3];
    logic signed [31:0] base_reg [3];
    logic               zero_out_reg;
    logic signed [31:0] pt [3];

    assign advance = !out_v_reg || m_ready;
    assign s_ready = advance && !busy;
    assign pt[0]   = s_point_x;
    assign pt[1]   = s_point_y;
    assign pt[2]   = s_point_z;

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (advance) begin
            v1_reg    <= s_valid && s_ready;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_v_reg <= v3_reg;
        end
    end

    // Data stages.
    always_ff @(posedge aclk) begin
        if (advance) begin
            z1_reg <= zero_reg;
            for (int k = 0; k < 9; k++) begin
                p1_reg[k] <= mat_reg[k] * pt[k % 3];
            end
            z2_reg <= z1_reg;
            for (int i = 0; i < 3; i++) begin
                acc2_reg[i] <= 67'(p1_reg[3*i]) + 67'(p1_reg[3*i+1]) + 67'(p1_reg[3*i+2]);
            end
            z3_reg <= z2_reg;
            for (int i = 0; i < 3; i++) begin
                sum3_reg[i] <= 38'((acc2_reg[i] + qpt_pkg::HALF_Q30) >>> 30) +
                               38'(shift_reg[i]);
            end
            zero_out_reg <= z3_reg;
            for (int i = 0; i < 3; i++) begin
                if (z3_reg) begin
                    base_reg[i] <= '0;
                end else if (sum3_reg[i] > 38'sd2147483647) begin
                    base_reg[i] <= 32'sh7FFF_FFFF;
                end else if (sum3_reg[i] < -38'sd2147483648) begin
                    base_reg[i] <= 32'sh8000_0000;
                end else begin
                    base_reg[i] <= sum3_reg[i][31:0];
                end
            end
        end
    end

    assign m_valid     = out_v_reg;
    assign m_base_x    = base_reg[0];
    assign m_base_y    = base_reg[1];
    assign m_base_z    = base_reg[2];
    assign m_zero_norm = zero_out_reg;

    // Checks.
    `QPT_ASSERT(a_rot_write_restarts, rot_wr |=> (state_reg == ST_LOAD), "rotation write did not restart normalization")
    `QPT_ASSERT(a_no_accept_busy, busy |-> !(s_valid && s_ready), "transfer accepted during normalization")
    `QPT_ASSERT(a_zero_outputs, (m_valid && m_zero_norm) |-> (m_base_x == '0 && m_base_y == '0 && m_base_z == '0), "zero quaternion with nonzero output")
    `QPT_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "output valid right after reset")

endmodule
